/* design/bga_pkg.sv */
package bga_pkg;

  localparam int unsigned MaxGranules = 4096;
  localparam int unsigned IdBits      = 8;
  localparam int unsigned HeadId      = 5;

  localparam logic [15:0] GranuleReset = 16'd16;
  localparam logic [12:0] RegionReset  = 13'd4096;

  // Result status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoRoom  = 2'd1;
  localparam logic [1:0] StBadOff  = 2'd2;
  localparam logic [1:0] StNotUsed = 2'd3;

  // Operation codes.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Register indexes.
  localparam logic RegGranule = 1'b0;
  localparam logic RegRegion  = 1'b1;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic        go;
    logic [32:0] dividend;
    logic [15:0] divisor;
  } bga_div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
    logic        rem_nz;
  } bga_div_rsp_t;

endpackage

/* design/bga_div.sv */
// Shared restoring divider: one quotient bit per cycle.
module bga_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bga_pkg::bga_div_req_t req,
  output bga_pkg::bga_div_rsp_t rsp
);

  logic [32:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  // One shift and trial subtract per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[15:0], quo_r[32]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.go) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.rem_nz   = (rem_r != '0);

endmodule

/* design/bitmap_granule_allocator.sv */
// A free clears granules; an allocate scans the owner map and tags granules, and its search
// may walk the whole map.
// The walk over the owner map memory and the shared divider pace each item.
// One item at a time; busy is high while an item is at work.
// After reset or a register write a clearing pass over the whole map, a divide and a fill
// of the reserved head rebuild the map, with busy high.
// Results are strobed for one cycle; no stall.
module bitmap_granule_allocator #(
  parameter int unsigned MAX_GRANULES = bga_pkg::MaxGranules,
  parameter int unsigned ID_BITS      = bga_pkg::IdBits
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [31:0]                         in_size_bytes,
  input  logic [27:0]                         in_offset_bytes,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [27:0]                         out_result_offset,
  output logic [$clog2(MAX_GRANULES+1)-1:0]   out_granules_used,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned AW = $clog2(MAX_GRANULES);
  localparam int unsigned CW = $clog2(MAX_GRANULES + 1);
  localparam logic [CW-1:0] NMax = CW'(MAX_GRANULES);
  localparam logic [ID_BITS-1:0] HeadIdV = ID_BITS'(bga_pkg::HeadId);

  // Sequencer states.
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_HDIV   = 5'd1;
  localparam logic [4:0] S_HWAIT  = 5'd2;
  localparam logic [4:0] S_HFILL  = 5'd3;
  localparam logic [4:0] S_IDLE   = 5'd4;
  localparam logic [4:0] S_AROOM  = 5'd5;
  localparam logic [4:0] S_ADIV   = 5'd6;
  localparam logic [4:0] S_AWAIT  = 5'd7;
  localparam logic [4:0] S_SRD    = 5'd8;
  localparam logic [4:0] S_SCHK   = 5'd9;
  localparam logic [4:0] S_LRD    = 5'd10;
  localparam logic [4:0] S_LGET   = 5'd11;
  localparam logic [4:0] S_RGET   = 5'd12;
  localparam logic [4:0] S_PICK   = 5'd13;
  localparam logic [4:0] S_TAG    = 5'd14;
  localparam logic [4:0] S_FDIV   = 5'd15;
  localparam logic [4:0] S_FWAIT  = 5'd16;
  localparam logic [4:0] S_FRD    = 5'd17;
  localparam logic [4:0] S_FCHK   = 5'd18;
  localparam logic [4:0] S_CRD    = 5'd19;
  localparam logic [4:0] S_CCHK   = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;
  localparam logic [4:0] S_MULT   = 5'd22;
  localparam logic [4:0] S_AROOM2 = 5'd23;

  // Owner map memory.
  logic [ID_BITS-1:0] mem [MAX_GRANULES];
  logic [ID_BITS-1:0] rd_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [ID_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [4:0]         st_r, st_nxt;
  logic [15:0]        gran_r, gran_nxt;
  logic [12:0]        region_r, region_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      sstart_r, sstart_nxt;
  logic [CW:0]        ptr_r, ptr_nxt;
  logic [CW:0]        k_r, k_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      y_r, y_nxt;
  logic [CW-1:0]      need_r, need_nxt;
  logic [ID_BITS-1:0] left_r, left_nxt;
  logic [ID_BITS-1:0] right_r, right_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [31:0]        size_r, size_nxt;
  logic               op_r, op_nxt;
  logic [47:0]        prod_r, prod_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [27:0]        roff_r, roff_nxt;
  logic               ov_r, ov_nxt;

  bga_pkg::bga_div_req_t dreq;
  bga_pkg::bga_div_rsp_t drsp;

  bga_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Effective granule size and region size.
  logic [15:0]   unit;
  logic [CW-1:0] n_eff;
  always_comb begin
    unit = (gran_r == 16'd0) ? 16'd1 : gran_r;
    if (region_r == 13'd0) begin
      n_eff = CW'(1);
    end else if ({{(CW > 13 ? CW - 13 : 0){1'b0}}, region_r} > (CW > 13 ? CW : 13)'(NMax)) begin
      n_eff = NMax;
    end else begin
      n_eff = CW'(region_r);
    end
  end

  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[2])
      bga_pkg::RegGranule: cfg_prdata = {16'd0, gran_r};
      bga_pkg::RegRegion:  cfg_prdata = {19'd0, region_r};
      default:             cfg_prdata = '0;
    endcase
  end

  logic [CW-1:0] pos_wrap;
  logic [CW-1:0] qn;
  logic [CW:0]   cur_end;
  assign qn = (drsp.quotient > 33'(n_eff)) ? n_eff : CW'(drsp.quotient);

  // Main sequencer.
  always_comb begin
    st_nxt     = st_r;
    gran_nxt   = gran_r;
    region_nxt = region_r;
    used_nxt   = used_r;
    head_nxt   = head_r;
    sstart_nxt = sstart_r;
    ptr_nxt    = ptr_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    y_nxt      = y_r;
    need_nxt   = need_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    id_nxt     = id_r;
    size_nxt   = size_r;
    op_nxt     = op_r;
    prod_nxt   = prod_r;
    status_nxt = status_r;
    roff_nxt   = roff_r;
    ov_nxt     = 1'b0;
    rd_addr    = ptr_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = ptr_r[AW-1:0];
    wr_data    = '0;
    dreq       = '0;
    pos_wrap   = '0;
    cur_end    = '0;

    unique case (st_r)
      S_CLR: begin
        wr_en = 1'b1;
        if (ptr_r == (CW+1)'(MAX_GRANULES - 1)) begin
          st_nxt = S_HDIV;
        end
        ptr_nxt = ptr_r + 1'b1;
      end
      S_HDIV: begin
        dreq.go       = 1'b1;
        dreq.dividend = 33'(n_eff);
        dreq.divisor  = unit;
        st_nxt        = S_HWAIT;
      end
      S_HWAIT: begin
        if (drsp.done) begin
          if (drsp.rem_nz && qn < n_eff) begin
            head_nxt = qn + 1'b1;
          end else begin
            head_nxt = qn;
          end
          ptr_nxt = '0;
          st_nxt  = S_HFILL;
        end
      end
      S_HFILL: begin
        if (ptr_r < {1'b0, head_r}) begin
          wr_en   = 1'b1;
          wr_data = HeadIdV;
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          sstart_nxt = AW'(head_r - 1'b1);
          used_nxt   = head_r;
          st_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          size_nxt   = in_size_bytes;
          status_nxt = bga_pkg::StOk;
          roff_nxt   = '0;
          if (in_op == bga_pkg::OpFree) begin
            dreq.go       = 1'b1;
            dreq.dividend = {5'd0, in_offset_bytes};
            dreq.divisor  = unit;
            st_nxt        = S_FWAIT;
          end else if (in_size_bytes == 32'd0) begin
            status_nxt = bga_pkg::StNoRoom;
            st_nxt     = S_OUT;
          end else begin
            st_nxt = S_AROOM;
          end
        end
      end
      S_AROOM: begin
        // Free room times granule size, registered before the compare.
        prod_nxt = 48'(n_eff - used_r) * 48'(unit);
        st_nxt   = S_AROOM2;
      end
      S_AROOM2: begin
        if (prod_r < 48'(size_r)) begin
          status_nxt = bga_pkg::StNoRoom;
          st_nxt     = S_OUT;
        end else begin
          st_nxt = S_ADIV;
        end
      end
      S_ADIV: begin
        dreq.go       = 1'b1;
        dreq.dividend = 33'(size_r) + 33'(unit) - 33'd1;
        dreq.divisor  = unit;
        st_nxt        = S_AWAIT;
      end
      S_AWAIT: begin
        if (drsp.done) begin
          if (drsp.quotient > 33'(n_eff)) begin
            status_nxt = bga_pkg::StNoRoom;
            st_nxt     = S_OUT;
          end else begin
            need_nxt = CW'(drsp.quotient);
            k_nxt    = '0;
            if ({1'b0, sstart_r} + 1'b1 >= (AW+1)'(n_eff)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = (CW+1)'(sstart_r) + 1'b1;
            end
            st_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        // Position k of the wrap walk; read its owner.
        if (k_r >= (CW+1)'(n_eff)) begin
          status_nxt = bga_pkg::StNoRoom;
          st_nxt     = S_OUT;
        end else begin
          pos_wrap = (ptr_r + k_r >= (CW+1)'(n_eff)) ? CW'(ptr_r + k_r - (CW+1)'(n_eff))
                                                   : CW'(ptr_r + k_r);
          pos_nxt  = pos_wrap;
          rd_addr  = AW'(pos_wrap);
          y_nxt    = '0;
          st_nxt   = S_SCHK;
        end
      end
      S_SCHK: begin
        // Grow the free run one granule per read.
        cur_end = (CW+1)'(pos_r) + (CW+1)'(y_r);
        if (y_r == need_r) begin
          rd_addr = AW'(pos_r - 1'b1);
          st_nxt  = S_LRD;
        end else if (rd_q != '0) begin
          k_nxt  = k_r + (CW+1)'(y_r) + ((y_r == '0) ? 1'b1 : 1'b0);
          st_nxt = S_SRD;
        end else begin
          y_nxt   = y_r + 1'b1;
          rd_addr = AW'(cur_end + 1'b1);
          if (y_r + 1'b1 != need_r && cur_end + 1'b1 >= (CW+1)'(n_eff)) begin
            k_nxt  = k_r + (CW+1)'(y_r) + 1'b1;
            st_nxt = S_SRD;
          end
        end
      end
      S_LRD: begin
        // The left neighbor arrives now; ask for the right one.
        left_nxt = (pos_r == '0) ? '0 : rd_q;
        rd_addr  = AW'((CW+1)'(pos_r) + (CW+1)'(need_r));
        st_nxt   = S_LGET;
      end
      S_LGET: begin
        right_nxt = ((CW+1)'(pos_r) + (CW+1)'(need_r) < (CW+1)'(n_eff)) ? rd_q : '0;
        st_nxt    = S_RGET;
      end
      S_RGET: begin
        id_nxt = left_r + 1'b1;
        st_nxt = S_PICK;
      end
      S_PICK: begin
        // Step the candidate id past the right id and zero.
        if (id_r == right_r || id_r == '0) begin
          id_nxt = id_r + 1'b1;
        end else begin
          ptr_nxt  = (CW+1)'(pos_r);
          prod_nxt = 48'(pos_r) * 48'(unit);
          st_nxt   = S_TAG;
        end
      end
      S_TAG: begin
        cur_end = (CW+1)'(pos_r) + (CW+1)'(need_r);
        if (ptr_r < cur_end) begin
          wr_en   = 1'b1;
          wr_data = id_r;
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          sstart_nxt = (cur_end >= (CW+1)'(2)) ? AW'(cur_end - (CW+1)'(2))
                                                : AW'(n_eff - 1'b1);
          used_nxt   = used_r + need_r;
          roff_nxt   = prod_r[27:0];
          status_nxt = bga_pkg::StOk;
          st_nxt     = S_OUT;
        end
      end
      S_FWAIT: begin
        if (drsp.done) begin
          if (drsp.quotient >= 33'(n_eff) || drsp.quotient < 33'(head_r)) begin
            status_nxt = bga_pkg::StBadOff;
            st_nxt     = S_OUT;
          end else begin
            ptr_nxt = (CW+1)'(drsp.quotient);
            st_nxt  = S_FRD;
          end
        end
      end
      S_FRD: begin
        st_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (rd_q == '0) begin
          status_nxt = bga_pkg::StNotUsed;
          st_nxt     = S_OUT;
        end else begin
          id_nxt = rd_q;
          st_nxt = S_CCHK;
        end
      end
      S_CRD: begin
        st_nxt = S_CCHK;
      end
      S_CCHK: begin
        // Clear while the id matches; the read at ptr is current.
        if (ptr_r < (CW+1)'(n_eff) && rd_q == id_r) begin
          wr_en    = 1'b1;
          used_nxt = used_r - 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
          rd_addr  = AW'(ptr_r + 1'b1);
          st_nxt   = S_CRD;
        end else begin
          status_nxt = bga_pkg::StOk;
          st_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      S_MULT: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // A register write restarts the map rebuild.
    if (cfg_wr) begin
      if (cfg_paddr[2] == bga_pkg::RegGranule) begin
        gran_nxt = cfg_pwdata[15:0];
      end else begin
        region_nxt = cfg_pwdata[12:0];
      end
      ptr_nxt = '0;
      st_nxt  = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      gran_r   <= bga_pkg::GranuleReset;
      region_r <= bga_pkg::RegionReset;
      ptr_r    <= '0;
      ov_r     <= 1'b0;
      used_r   <= '0;
      sstart_r <= '0;
      head_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      gran_r   <= gran_nxt;
      region_r <= region_nxt;
      ptr_r    <= ptr_nxt;
      ov_r     <= ov_nxt;
      used_r   <= used_nxt;
      sstart_r <= sstart_nxt;
      head_r   <= head_nxt;
    end
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    y_r      <= y_nxt;
    need_r   <= need_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    id_r     <= id_nxt;
    size_r   <= size_nxt;
    op_r     <= op_nxt;
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
    roff_r   <= roff_nxt;
  end

  assign busy              = (st_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_status        = status_r;
  assign out_result_offset = (status_r == bga_pkg::StOk && op_r == bga_pkg::OpAlloc) ? roff_r
                                                                                     : '0;
  assign out_granules_used = used_r;

endmodule
